// ----- sv/two_level_bitmap_find_next_top_defines.svh -----
// Assertion macros for the two-level bitmap find-next block.
// Used by the checker module; expects aclk and aresetn in scope.
`ifndef TWO_LEVEL_BITMAP_FIND_NEXT_TOP_DEFINES_SVH
`define TWO_LEVEL_BITMAP_FIND_NEXT_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TLBF_ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define TLBF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- sv/tlbf_pkg.sv -----
// Shared types and constants of the two-level bitmap find-next block.
// No dependencies; imported by the arithmetic unit and the top level.
`timescale 1ns / 1ps

package tlbf_pkg;

    // Fixed widths of the transaction fields and the size register.
    localparam int IDX_W     = 11;
    localparam int SIZE_W    = 12;
    localparam int OP_W      = 2;
    localparam int IDX_SPAN  = 2048;

    // Width of the shared arithmetic unit and the reciprocal shift.
    localparam int UW        = 22;
    localparam int DIV_SHIFT = 12;

    // Operation codes of an input transaction.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Register index of size_bits, taken from paddr bit 2.
    localparam logic REG_IDX_SIZE_BITS = 1'b0;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd2048;

    // Arithmetic unit operations.
    typedef logic [1:0] uop_t;
    localparam uop_t UOP_ADD = 2'd0;
    localparam uop_t UOP_SUB = 2'd1;
    localparam uop_t UOP_MUL = 2'd2;

    typedef struct packed {
        uop_t          op;
        logic [UW-1:0] a;
        logic [UW-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic [UW-1:0] res;
        logic          lt;
    } unit_rsp_t;

endpackage

// ----- sv/tlbf_alu.sv -----
// Shared arithmetic unit: add, subtract with less-than flag, small multiply.
// Depends on tlbf_pkg for the request and response structures.
`timescale 1ns / 1ps

module tlbf_alu (
    input  tlbf_pkg::unit_req_t req,
    output tlbf_pkg::unit_rsp_t rsp
);
    import tlbf_pkg::*;

    // One operation per cycle, chosen by the sequencer.
    always_comb begin
        rsp.lt = (req.a < req.b);
        case (req.op)
            UOP_ADD: begin
                rsp.res = req.a + req.b;
            end
            UOP_SUB: begin
                rsp.res = req.a - req.b;
            end
            UOP_MUL: begin
                rsp.res = req.a * req.b;
            end
            default: begin
                rsp.res = '0;
            end
        endcase
    end

endmodule

// ----- sv/tlbf_ffs.sv -----
// Find-first-set search with a lower bound on the bit position.
// No dependencies; used for both store words and the summary word.
`timescale 1ns / 1ps

module tlbf_ffs #(
    parameter int FW  = 64,
    parameter int FIW = $clog2(FW),
    parameter int LW  = FIW + 1
) (
    input  logic [FW-1:0]  vec,
    input  logic [LW-1:0]  lo,
    output logic           hit,
    output logic [FIW-1:0] idx
);

    // Scan from the top so that the lowest qualifying bit wins.
    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = FW - 1; i >= 0; i--) begin
            if (vec[i] && (LW'(i) >= lo)) begin
                hit = 1'b1;
                idx = FIW'(i);
            end
        end
    end

endmodule

// ----- sv/two_level_bitmap_find_next_top.sv -----
// Channel   Direction  Signals                                   Moves
// s_        in         s_valid/s_ready, s_operation, s_index     one request
// m_        out        m_valid/m_ready, m_ok, m_found, ...       one result
// apb       in/out     psel, penable, pwrite, paddr, pwdata      size_bits
//
// A request steps through the sequencer states in order, and a clear goes
// straight to the result. The shared arithmetic unit is used once per step:
// reciprocal divide, correction, range check and position add.
// aresetn is synchronous and active low; it empties the set at once.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its result waits until the previous one is taken.
// Depends on tlbf_pkg, tlbf_alu and tlbf_ffs.
`timescale 1ns / 1ps

module two_level_bitmap_find_next_top #(
    parameter int NUM_WORDS = 32,
    parameter int WORD_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlbf_pkg::OP_W-1:0]     s_operation,
    input  logic [tlbf_pkg::IDX_W-1:0]    s_index,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic                          m_found,
    output logic [tlbf_pkg::IDX_W-1:0]    m_position,
    output logic                          m_empty_res
);
    import tlbf_pkg::*;

    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int QW        = $clog2(IDX_SPAN / WORD_BITS + 1);
    localparam int RW        = $clog2(WORD_BITS);
    localparam int FW        = (WORD_BITS > NUM_WORDS) ? WORD_BITS : NUM_WORDS;
    localparam int FIW       = $clog2(FW);
    localparam int LW        = FIW + 1;
    localparam int RECIP     = (1 << DIV_SHIFT) / WORD_BITS;
    localparam int CAP_MAX   = NUM_WORDS * WORD_BITS;
    localparam int CAP_RESET = (CAP_MAX < IDX_SPAN) ? CAP_MAX : IDX_SPAN;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QEST   = 4'd1;
    localparam logic [3:0] S_BASE   = 4'd2;
    localparam logic [3:0] S_REM    = 4'd3;
    localparam logic [3:0] S_FIX    = 4'd4;
    localparam logic [3:0] S_RANGE  = 4'd5;
    localparam logic [3:0] S_CHK    = 4'd6;
    localparam logic [3:0] S_WRITE  = 4'd7;
    localparam logic [3:0] S_FIND1  = 4'd8;
    localparam logic [3:0] S_SUMM   = 4'd9;
    localparam logic [3:0] S_FIND2  = 4'd10;
    localparam logic [3:0] S_POS    = 4'd11;
    localparam logic [3:0] S_RESULT = 4'd12;

    logic [3:0]           state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [RW:0]          rem_reg, rem_next;
    logic [SIZE_W-1:0]    base_reg, base_next;
    logic [FIW-1:0]       lsb_reg, lsb_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic                 ok_reg, ok_next;
    logic                 found_reg, found_next;
    logic [NUM_WORDS-1:0] summary_reg, summary_next;
    logic [SIZE_W-1:0]    size_bits_reg, size_bits_next;
    logic [SIZE_W-1:0]    cap_limit_reg, cap_limit_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_ok_reg, m_ok_next;
    logic                 m_found_reg, m_found_next;
    logic [IDX_W-1:0]     m_position_reg, m_position_next;
    logic                 m_empty_reg, m_empty_next;

    // Word store and its registered read port.
    logic [WORD_BITS-1:0] word_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic                 mem_we;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] bit_mask;

    unit_req_t            alu_req;
    unit_rsp_t            alu_rsp;
    logic [FW-1:0]        ffs_vec;
    logic [LW-1:0]        ffs_lo;
    logic                 ffs_hit;
    logic [FIW-1:0]       ffs_idx;
    logic                 cfg_wr;
    logic                 cfg_fits;

    tlbf_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    tlbf_ffs #(
        .FW  (FW),
        .FIW (FIW),
        .LW  (LW)
    ) u_ffs (
        .vec (ffs_vec),
        .lo  (ffs_lo),
        .hit (ffs_hit),
        .idx (ffs_idx)
    );

    // A word whose summary bit is clear reads as zero.
    assign rd_word  = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask = WORD_BITS'(1) << rem_reg[RW-1:0];

    // Configuration port decode.
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_IDX_SIZE_BITS);
    assign cfg_fits = ({1'b0, pwdata[SIZE_W-1:0]} <= (SIZE_W + 1)'(CAP_MAX));

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDX_SIZE_BITS) begin
            prdata = 32'(size_bits_reg);
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_ok        = m_ok_reg;
    assign m_found     = m_found_reg;
    assign m_position  = m_position_reg;
    assign m_empty_res = m_empty_reg;

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        base_next       = base_reg;
        lsb_next        = lsb_reg;
        pos_next        = pos_reg;
        ok_next         = ok_reg;
        found_next      = found_reg;
        summary_next    = summary_reg;
        size_bits_next  = size_bits_reg;
        cap_limit_next  = cap_limit_reg;
        m_valid_next    = m_valid_reg;
        m_ok_next       = m_ok_reg;
        m_found_next    = m_found_reg;
        m_position_next = m_position_reg;
        m_empty_next    = m_empty_reg;
        alu_req         = '{op: UOP_ADD, a: '0, b: '0};
        ffs_vec         = '0;
        ffs_lo          = '0;
        mem_we          = 1'b0;
        mem_rd_en       = 1'b0;
        mem_addr        = q_reg[AW-1:0];
        mem_wdata       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // A size write that fits sets the capacity and empties the set.
        if (cfg_wr && cfg_fits) begin
            size_bits_next = pwdata[SIZE_W-1:0];
            cap_limit_next = pwdata[SIZE_W-1:0];
            summary_next   = '0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    idx_next   = s_index;
                    ok_next    = 1'b0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    if (s_operation == OP_CLEAR) begin
                        summary_next = '0;
                        ok_next      = 1'b1;
                        state_next   = S_RESULT;
                    end else begin
                        state_next = S_QEST;
                    end
                end
            end
            // Word estimate: index times the reciprocal of the word width.
            S_QEST: begin
                alu_req    = '{op: UOP_MUL, a: UW'(idx_reg), b: UW'(RECIP)};
                q_next     = alu_rsp.res[DIV_SHIFT +: QW];
                state_next = S_BASE;
            end
            S_BASE: begin
                alu_req    = '{op: UOP_MUL, a: UW'(q_reg), b: UW'(WORD_BITS)};
                base_next  = alu_rsp.res[SIZE_W-1:0];
                state_next = S_REM;
            end
            S_REM: begin
                alu_req    = '{op: UOP_SUB, a: UW'(idx_reg), b: UW'(base_reg)};
                rem_next   = alu_rsp.res[RW:0];
                state_next = S_FIX;
            end
            // The estimate may be one word short; correct it once.
            S_FIX: begin
                alu_req = '{op: UOP_SUB, a: UW'(rem_reg), b: UW'(WORD_BITS)};
                if (!alu_rsp.lt) begin
                    rem_next = alu_rsp.res[RW:0];
                    q_next   = q_reg + QW'(1);
                end
                state_next = S_RANGE;
            end
            S_RANGE: begin
                alu_req    = '{op: UOP_SUB, a: UW'(idx_reg), b: UW'(rem_reg)};
                base_next  = alu_rsp.res[SIZE_W-1:0];
                state_next = S_CHK;
            end
            // In range when the word's first bit lies below the requested size.
            S_CHK: begin
                alu_req = '{op: UOP_SUB, a: UW'(base_reg), b: UW'(cap_limit_reg)};
                if (alu_rsp.lt) begin
                    ok_next   = 1'b1;
                    mem_rd_en = 1'b1;
                    if (op_reg == OP_FIND) begin
                        state_next = S_FIND1;
                    end else begin
                        state_next = S_WRITE;
                    end
                end else begin
                    state_next = S_RESULT;
                end
            end
            // Read-modify-write of the word, with its summary bit.
            S_WRITE: begin
                mem_we = 1'b1;
                if (op_reg == OP_INSERT) begin
                    mem_wdata = rd_word | bit_mask;
                end else begin
                    mem_wdata = rd_word & ~bit_mask;
                end
                summary_next[q_reg[AW-1:0]] = |mem_wdata;
                state_next = S_RESULT;
            end
            // Search the indexed word from the bit position upwards.
            S_FIND1: begin
                ffs_vec = FW'(rd_word);
                ffs_lo  = LW'(rem_reg[RW-1:0]);
                if (ffs_hit) begin
                    lsb_next   = ffs_idx;
                    found_next = 1'b1;
                    state_next = S_POS;
                end else begin
                    state_next = S_SUMM;
                end
            end
            // Next non-empty word above the indexed one, from the summary.
            S_SUMM: begin
                ffs_vec = FW'(summary_reg);
                ffs_lo  = LW'(q_reg[AW-1:0]) + LW'(1);
                if (ffs_hit) begin
                    q_next     = QW'(ffs_idx);
                    mem_addr   = ffs_idx[AW-1:0];
                    mem_rd_en  = 1'b1;
                    found_next = 1'b1;
                    state_next = S_FIND2;
                end else begin
                    state_next = S_RESULT;
                end
            end
            // The flagged word is non-empty, so its lowest bit always exists.
            S_FIND2: begin
                ffs_vec    = FW'(rd_data_reg);
                ffs_lo     = '0;
                lsb_next   = ffs_idx;
                alu_req    = '{op: UOP_MUL, a: UW'(q_reg), b: UW'(WORD_BITS)};
                base_next  = alu_rsp.res[SIZE_W-1:0];
                state_next = S_POS;
            end
            S_POS: begin
                alu_req    = '{op: UOP_ADD, a: UW'(base_reg), b: UW'(lsb_reg)};
                pos_next   = alu_rsp.res[IDX_W-1:0];
                state_next = S_RESULT;
            end
            // Load the output register once it is free.
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_ok_next       = ok_reg;
                    m_found_next    = found_reg;
                    m_position_next = found_reg ? pos_reg : '0;
                    m_empty_next    = (summary_reg == '0);
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            summary_reg   <= '0;
            size_bits_reg <= SIZE_RESET;
            cap_limit_reg <= SIZE_W'(CAP_RESET);
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            summary_reg   <= summary_next;
            size_bits_reg <= size_bits_next;
            cap_limit_reg <= cap_limit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        base_reg       <= base_next;
        lsb_reg        <= lsb_next;
        pos_reg        <= pos_next;
        ok_reg         <= ok_next;
        found_reg      <= found_next;
        m_ok_reg       <= m_ok_next;
        m_found_reg    <= m_found_next;
        m_position_reg <= m_position_next;
        m_empty_reg    <= m_empty_next;
    end

    // Word store: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            word_mem[mem_addr] <= mem_wdata;
        end
        if (mem_rd_en) begin
            rd_data_reg  <= word_mem[mem_addr];
            rd_valid_reg <= summary_reg[mem_addr];
        end
    end

endmodule

// ----- sv/tlbf_checker.sv -----
// Port-level checks for the two-level bitmap find-next block, with its bind.
// Depends on two_level_bitmap_find_next_top_defines.svh for the macros.
`timescale 1ns / 1ps

`include "two_level_bitmap_find_next_top_defines.svh"

module tlbf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_operation,
    input logic [10:0] s_index,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_ok,
    input logic        m_found,
    input logic [10:0] m_position,
    input logic        m_empty_res
);

    // A result waiting for the sink keeps its payload.
    `TLBF_ASSERT_ON(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_found) && $stable(m_ok), "result changed while stalled")

    // Reset leaves no result pending.
    `TLBF_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

    // The block works on one request at a time.
    `TLBF_ASSERT_ON(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "request taken while busy")

    // A found position implies an accepted index and a non-empty set.
    `TLBF_ASSERT_ON(a_found_consistent, m_valid && m_found |-> m_ok && !m_empty_res, "found with empty set or rejected index")

    // Without a hit the position reads as zero.
    `TLBF_ASSERT_ON(a_position_zero, m_valid && !m_found |-> m_position == 11'd0, "position set without a hit")

endmodule

bind two_level_bitmap_find_next_top tlbf_checker u_tlbf_checker (.*);
